### rtl/fmtl_pkg.sv
// Package: shared types, constants and helper functions of the field map lookup.
`timescale 1ns / 1ps
package fmtl_pkg;

  localparam int GRID_X  = 64;
  localparam int GRID_Y  = 16;
  localparam int GRID_Z  = 64;
  localparam int GRID_YZ = GRID_Y * GRID_Z;

  localparam int TABLE_AW    = 16;
  localparam int TABLE_DEPTH = 1 << TABLE_AW;
  localparam int DATA_W      = 24;
  localparam int STEP_W      = 16;
  localparam int FRAC_W      = 16;
  localparam int CELL_W      = 10;
  localparam int QUOT_W      = CELL_W + FRAC_W;
  localparam int OFF_W       = 27;
  localparam int LOC_W       = 26;
  localparam int PROD_W      = DATA_W + 1 + FRAC_W + 1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CENTRE_X = 3'd0;
  localparam logic [2:0] CFG_CENTRE_Y = 3'd1;
  localparam logic [2:0] CFG_CENTRE_Z = 3'd2;
  localparam logic [2:0] CFG_X_LOW    = 3'd3;
  localparam logic [2:0] CFG_Y_LOW    = 3'd4;
  localparam logic [2:0] CFG_Z_LOW    = 3'd5;
  localparam logic [2:0] CFG_STEP     = 3'd6;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                     op;
    logic [TABLE_AW-1:0]      entry_index;
    logic signed [DATA_W-1:0] load_bx;
    logic signed [DATA_W-1:0] load_by;
    logic signed [DATA_W-1:0] load_bz;
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_y;
    logic signed [DATA_W-1:0] point_z;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_bx;
    logic signed [DATA_W-1:0] out_by;
    logic signed [DATA_W-1:0] out_bz;
    logic                     inside_res;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DLOAD, S_DSTEP, S_DSTORE, S_ADDR, S_READ, S_LMUL, S_LACC, S_FIN
  } state_t;

  typedef struct packed {
    logic       wr;
    logic       cap;
    logic       check;
    logic       div_load;
    logic       div_step;
    logic       div_store;
    logic [1:0] axis;
    logic       addr;
    logic       rd_en;
    logic [2:0] corner;
    logic       rd_cap;
    logic [2:0] rd_idx;
    logic       lmul;
    logic       lacc;
    logic [2:0] lstep;
    logic       fin;
  } dp_cmd_t;

  typedef struct packed {
    logic in_map;
    logic out_full;
  } dp_sts_t;

  // Address offset of corner k (bit 2 = x, bit 1 = y, bit 0 = z) from the cell base.
  function automatic logic [TABLE_AW-1:0] corner_ofs(input logic [2:0] k);
    corner_ofs = TABLE_AW'(int'(k[2]) * GRID_YZ + int'(k[1]) * GRID_Z + int'(k[0]));
  endfunction

  // Reduction schedule: x steps fold 4 pairs, y steps 2, z step 1.
  function automatic logic [2:0] lerp_a(input logic [2:0] s);
    case (s)
      3'd0, 3'd1, 3'd2, 3'd3: lerp_a = s;
      3'd4:                   lerp_a = 3'd0;
      3'd5:                   lerp_a = 3'd1;
      default:                lerp_a = 3'd0;
    endcase
  endfunction

  function automatic logic [2:0] lerp_b(input logic [2:0] s);
    case (s)
      3'd0, 3'd1, 3'd2, 3'd3: lerp_b = s + 3'd4;
      3'd4:                   lerp_b = 3'd2;
      3'd5:                   lerp_b = 3'd3;
      default:                lerp_b = 3'd1;
    endcase
  endfunction

  function automatic logic [1:0] lerp_axis(input logic [2:0] s);
    case (s)
      3'd0, 3'd1, 3'd2, 3'd3: lerp_axis = 2'd0;
      3'd4, 3'd5:             lerp_axis = 2'd1;
      default:                lerp_axis = 2'd2;
    endcase
  endfunction

endpackage

### rtl/fmtl_if.sv
// Interfaces: valid/ready channels for input words and result words.
`timescale 1ns / 1ps
interface fmtl_in_if import fmtl_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fmtl_out_if import fmtl_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/fmtl_ctrl.sv
// Controller: sequences range check, division, corner reads and interpolation.
`timescale 1ns / 1ps
module fmtl_ctrl import fmtl_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_op,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output logic    in_ready,
  output dp_cmd_t cmd
);

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [1:0] axis_r, axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      axis_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    axis_nxt   = axis_r;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.axis   = axis_r;
    cmd.corner = cnt_r[2:0];
    cmd.rd_idx = 3'(cnt_r - 5'd1);
    cmd.lstep  = cnt_r[2:0];
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_QUERY) begin
            cmd.cap   = 1'b1;
            state_nxt = S_CHECK;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        axis_nxt  = '0;
        state_nxt = S_DLOAD;
      end
      S_DLOAD: begin
        if (!sts.in_map) begin
          state_nxt = S_FIN;
        end else begin
          cmd.div_load = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_DSTEP;
        end
      end
      S_DSTEP: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'(QUOT_W - 1)) begin
          state_nxt = S_DSTORE;
        end
      end
      S_DSTORE: begin
        cmd.div_store = 1'b1;
        if (axis_r == 2'd2) begin
          state_nxt = S_ADDR;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_DLOAD;
        end
      end
      S_ADDR: begin
        cmd.addr  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd_en  = (cnt_r != 5'd8);
        cmd.rd_cap = (cnt_r != 5'd0);
        if (cnt_r == 5'd8) begin
          cnt_nxt   = '0;
          state_nxt = S_LMUL;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_LMUL: begin
        cmd.lmul  = 1'b1;
        state_nxt = S_LACC;
      end
      S_LACC: begin
        cmd.lacc = 1'b1;
        if (cnt_r == 5'd6) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt   = cnt_r + 5'd1;
          state_nxt = S_LMUL;
        end
      end
      S_FIN: begin
        if (!sts.out_full || out_ready) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### rtl/fmtl_dp.sv
// Datapath: configuration, grid tables, shared divider, lerp lanes and output register.
`timescale 1ns / 1ps
module fmtl_dp import fmtl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  input  in_word_t    in_word,
  input  dp_cmd_t     cmd,
  input  logic        out_ready,
  output dp_sts_t     sts,
  output logic        out_valid,
  output out_word_t   out_word
);

  logic signed [DATA_W-1:0] centre_r [3];
  logic signed [DATA_W-1:0] low_r [3];
  logic [STEP_W-1:0]        step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_r[0] <= '0;
      centre_r[1] <= '0;
      centre_r[2] <= '0;
      low_r[0]    <= '0;
      low_r[1]    <= -24'sd25600;
      low_r[2]    <= '0;
      step_r      <= 16'd640;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTRE_X: centre_r[0] <= cfg_wdata;
        CFG_CENTRE_Y: centre_r[1] <= cfg_wdata;
        CFG_CENTRE_Z: centre_r[2] <= cfg_wdata;
        CFG_X_LOW:    low_r[0]    <= cfg_wdata;
        CFG_Y_LOW:    low_r[1]    <= cfg_wdata;
        CFG_Z_LOW:    low_r[2]    <= cfg_wdata;
        CFG_STEP:     step_r      <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Local coordinates; x and z folded to their magnitude.
  logic signed [LOC_W-1:0] loc_r [3];
  logic                    neg_x_r, neg_z_r;
  logic signed [LOC_W-1:0] dx, dy, dz;

  assign dx = LOC_W'(in_word.point_x) - LOC_W'(centre_r[0]);
  assign dy = LOC_W'(in_word.point_y) - LOC_W'(centre_r[1]);
  assign dz = LOC_W'(in_word.point_z) - LOC_W'(centre_r[2]);

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      loc_r[0] <= dx[LOC_W-1] ? -dx : dx;
      loc_r[1] <= dy;
      loc_r[2] <= dz[LOC_W-1] ? -dz : dz;
      neg_x_r  <= dx[LOC_W-1];
      neg_z_r  <= dz[LOC_W-1];
    end
  end

  // Range check against [low, low + (count-1)*step).
  logic [QUOT_W-1:0]       off_r [3];
  logic                    inside_r;
  logic signed [OFF_W-1:0] off_c [3];
  logic [QUOT_W-1:0]       lim_c [3];
  logic [2:0]              in_c;

  always_comb begin
    lim_c[0] = QUOT_W'((GRID_X - 1) * int'(step_r));
    lim_c[1] = QUOT_W'((GRID_Y - 1) * int'(step_r));
    lim_c[2] = QUOT_W'((GRID_Z - 1) * int'(step_r));
    for (int a = 0; a < 3; a++) begin
      off_c[a] = OFF_W'(loc_r[a]) - OFF_W'(low_r[a]);
      in_c[a]  = !off_c[a][OFF_W-1] && (off_c[a][QUOT_W] == 1'b0)
                 && (off_c[a][QUOT_W-1:0] < lim_c[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      for (int a = 0; a < 3; a++) begin
        off_r[a] <= off_c[a][QUOT_W-1:0];
      end
      inside_r <= &in_c;
    end
  end

  // Shared restoring divider: floor(off * 2^16 / step) gives cell and fraction.
  logic [STEP_W-1:0] rem_r;
  logic [QUOT_W-1:0] quo_r;
  logic [CELL_W-1:0] cell_r [3];
  logic [FRAC_W-1:0] frac_r [3];
  logic [STEP_W:0]   trial;
  logic              q_bit;

  assign trial = {rem_r, quo_r[QUOT_W-1]};
  assign q_bit = (trial >= {1'b0, step_r});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r <= off_r[cmd.axis][QUOT_W-1:CELL_W];
      quo_r <= {off_r[cmd.axis][CELL_W-1:0], {FRAC_W{1'b0}}};
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? STEP_W'(trial - {1'b0, step_r}) : trial[STEP_W-1:0];
      quo_r <= {quo_r[QUOT_W-2:0], q_bit};
    end
    if (cmd.div_store) begin
      cell_r[cmd.axis] <= quo_r[QUOT_W-1:FRAC_W];
      frac_r[cmd.axis] <= quo_r[FRAC_W-1:0];
    end
  end

  // Base address of the cell's low corner.
  logic [TABLE_AW-1:0] base_r;
  always_ff @(posedge clk) begin
    if (cmd.addr) begin
      base_r <= TABLE_AW'(int'(cell_r[0]) * GRID_YZ + int'(cell_r[1]) * GRID_Z
                          + int'(cell_r[2]));
    end
  end

  // Grid tables, one per component.
  logic [DATA_W-1:0]   mem_bx [TABLE_DEPTH];
  logic [DATA_W-1:0]   mem_by [TABLE_DEPTH];
  logic [DATA_W-1:0]   mem_bz [TABLE_DEPTH];
  logic [DATA_W-1:0]   rd_r [3];
  logic [TABLE_AW-1:0] raddr;

  assign raddr = base_r + corner_ofs(cmd.corner);

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem_bx[in_word.entry_index] <= in_word.load_bx;
    end
    if (cmd.rd_en) begin
      rd_r[0] <= mem_bx[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem_by[in_word.entry_index] <= in_word.load_by;
    end
    if (cmd.rd_en) begin
      rd_r[1] <= mem_by[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem_bz[in_word.entry_index] <= in_word.load_bz;
    end
    if (cmd.rd_en) begin
      rd_r[2] <= mem_bz[raddr];
    end
  end

  // Three lerp lanes, reduced in place over seven multiply and accumulate steps.
  logic signed [DATA_W-1:0] w_r [3][8];
  logic signed [PROD_W-1:0] prod_r [3];
  logic signed [DATA_W-1:0] a_r [3];
  logic [2:0]               ia, ib;
  logic signed [FRAC_W:0]   f_s;

  assign ia  = lerp_a(cmd.lstep);
  assign ib  = lerp_b(cmd.lstep);
  assign f_s = $signed({1'b0, frac_r[lerp_axis(cmd.lstep)]});

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (cmd.rd_cap) begin
        w_r[c][cmd.rd_idx] <= rd_r[c];
      end
      if (cmd.lmul) begin
        prod_r[c] <= PROD_W'(25'(w_r[c][ib]) - 25'(w_r[c][ia])) * PROD_W'(f_s);
        a_r[c]    <= w_r[c][ia];
      end
      if (cmd.lacc) begin
        w_r[c][ia] <= a_r[c] + DATA_W'((prod_r[c] + PROD_W'(32768)) >>> FRAC_W);
      end
    end
  end

  // Output register with mirrored-sign handling.
  logic signed [DATA_W-1:0] vx, vz;
  logic                     out_valid_r;
  out_word_t                out_r;

  assign vx = (w_r[0][0] == {1'b1, {(DATA_W-1){1'b0}}}) ? {1'b0, {(DATA_W-1){1'b1}}}
                                                         : -w_r[0][0];
  assign vz = (w_r[2][0] == {1'b1, {(DATA_W-1){1'b0}}}) ? {1'b0, {(DATA_W-1){1'b1}}}
                                                         : -w_r[2][0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      if (inside_r) begin
        out_r.out_bx     <= neg_x_r ? vx : w_r[0][0];
        out_r.out_by     <= w_r[1][0];
        out_r.out_bz     <= neg_z_r ? vz : w_r[2][0];
        out_r.inside_res <= 1'b1;
      end else begin
        out_r <= '0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_word     = out_r;
  assign sts.in_map   = inside_r;
  assign sts.out_full = out_valid_r;

endmodule

### rtl/field_map_trilinear_lookup_core.sv
// Top level: trilinear field map lookup with controller, datapath and channel ports.
`timescale 1ns / 1ps
// The block holds three 65536-entry tables of field components and answers point queries
// by trilinear interpolation of the eight corners of the enclosing grid cell.
// Input channel in_ch carries one word per handshake. A load word (op clear) writes
// entry_index of all three tables in the cycle it is accepted and produces no result.
// A query word (op set) produces exactly one result word on out_ch.
// Configuration is written through cfg_we, cfg_index and cfg_wdata while the block is idle.
// A load leaves the controller idle, ready for the next word. A query that falls outside
// the map goes from the range check straight to the result; one inside first passes the
// single shared restoring divider, which forms cell index and fraction for each axis in
// turn, then the corner reads through the one read port of each table and seven multiply
// and accumulate steps in the lanes. The next word is taken only once the result is
// written to the output register. Results sit in that register: while the receiver
// stalls, the block keeps working on the next query and waits only when it must replace
// a result not yet taken.
// Reset (synchronous, rst_n low) returns the configuration to its defaults and empties
// the output register; table contents are not cleared and must be loaded before use.
module field_map_trilinear_lookup_core import fmtl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  fmtl_in_if.sink     in_ch,
  fmtl_out_if.source  out_ch
);

  dp_cmd_t   cmd;
  dp_sts_t   sts;
  logic      in_ready;
  logic      out_valid;
  out_word_t out_word;

  fmtl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.data.op),
    .out_ready(out_ch.ready),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  fmtl_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_word  (in_ch.data),
    .cmd      (cmd),
    .out_ready(out_ch.ready),
    .sts      (sts),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_word;

  // A result word that reports an outside point carries zero fields.
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.data.inside_res |->
      out_ch.data.out_bx == '0 && out_ch.data.out_by == '0 && out_ch.data.out_bz == '0)
    else $error("outside result with nonzero field");

  // After a query is accepted the block is busy for at least the range check.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.data.op == OP_QUERY |=> !in_ch.ready)
    else $error("input taken during query");

  // A load never produces a result word on its own.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.data.op == OP_LOAD && !out_ch.valid |=> !out_ch.valid)
    else $error("result appeared after load");

endmodule

### tb/sv/tb_top.sv
// Testbench for the trilinear field map lookup core: queued words, shadow predictor, checker.
`timescale 1ns / 1ps
module tb_top import fmtl_pkg::*; ();

  // The clock runs at 10 ns. Reset is held low only at the start of the run.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_CENTRE_X;
  logic [23:0] cfg_wdata = '0;

  fmtl_in_if  in_ch();
  fmtl_out_if out_ch();

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
  end

  field_map_trilinear_lookup_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #5 clk = ~clk;

  localparam longint RUN_LIMIT = 1500000;

  // Shadow copy of the configuration and of the three component tables.
  longint centre_x_r, centre_y_r, centre_z_r;
  longint x_low_r, y_low_r, z_low_r;
  longint step_r;
  logic signed [DATA_W-1:0] tab_bx [TABLE_DEPTH];
  logic signed [DATA_W-1:0] tab_by [TABLE_DEPTH];
  logic signed [DATA_W-1:0] tab_bz [TABLE_DEPTH];
  // Entries that the queued loads will have written; queries only touch these.
  bit loaded [TABLE_DEPTH];

  in_word_t  words_to_send [$];
  out_word_t field_due [$];
  int        fail_count = 0;
  int        words_taken = 0;
  int        words_queued = 0;
  longint    cycle_count = 0;

  function automatic logic [TABLE_AW-1:0] flat_addr(int ix, int iy, int iz);
    return TABLE_AW'(ix * GRID_YZ + iy * GRID_Z + iz);
  endfunction

  // Finds the cell and the 0.16 fraction of one local coordinate, or reports it outside.
  function automatic bit axis_cell(longint l, longint low, int count,
                                   output int cell_idx, output int frac);
    longint hi;
    longint off;
    cell_idx = 0;
    frac = 0;
    hi = low + longint'(count - 1) * step_r;
    if (!(l >= low && l < hi) || step_r == 0) return 1'b0;
    off      = l - low;
    cell_idx = int'(off / step_r);
    frac     = int'(((off % step_r) << 16) / step_r);
    return 1'b1;
  endfunction

  function automatic bit locate_point(in_word_t w, output int ix, output int iy,
                                      output int iz, output int fx, output int fy,
                                      output int fz);
    longint lx;
    longint ly;
    longint lz;
    bit     ok;
    lx = longint'(w.point_x) - centre_x_r;
    ly = longint'(w.point_y) - centre_y_r;
    lz = longint'(w.point_z) - centre_z_r;
    if (lx < 0) lx = -lx;
    if (lz < 0) lz = -lz;
    ok = axis_cell(lx, x_low_r, GRID_X, ix, fx);
    ok = axis_cell(ly, y_low_r, GRID_Y, iy, fy) && ok;
    ok = axis_cell(lz, z_low_r, GRID_Z, iz, fz) && ok;
    return ok;
  endfunction

  // One linear step, rounding half up; the arithmetic shift floors negative values.
  function automatic longint lerp_fix(longint a, longint b, int f);
    return a + (((b - a) * longint'(f) + 32768) >>> 16);
  endfunction

  // Corner k carries the x offset in bit 2, y in bit 1 and z in bit 0.
  function automatic longint blend(longint c [8], int fx, int fy, int fz);
    longint b [4];
    longint d [2];
    for (int k = 0; k < 4; k++) b[k] = lerp_fix(c[k], c[k + 4], fx);
    for (int k = 0; k < 2; k++) d[k] = lerp_fix(b[k], b[k + 2], fy);
    return lerp_fix(d[0], d[1], fz);
  endfunction

  function automatic logic [DATA_W-1:0] negate_sat(longint v);
    longint n;
    n = -v;
    if (n > 8388607) n = 8388607;
    return n[DATA_W-1:0];
  endfunction

  // Expected result of one query word, from the shadow tables and configuration.
  function automatic out_word_t predict_field(in_word_t w);
    out_word_t        o;
    int               ix, iy, iz, fx, fy, fz;
    longint           cx [8];
    longint           cy [8];
    longint           cz [8];
    longint           vx, vy, vz;
    logic [TABLE_AW-1:0] a;
    o = '0;
    if (!locate_point(w, ix, iy, iz, fx, fy, fz)) return o;
    for (int k = 0; k < 8; k++) begin
      a = flat_addr(ix + k[2], iy + k[1], iz + k[0]);
      cx[k] = tab_bx[a];
      cy[k] = tab_by[a];
      cz[k] = tab_bz[a];
    end
    vx = blend(cx, fx, fy, fz);
    vy = blend(cy, fx, fy, fz);
    vz = blend(cz, fx, fy, fz);
    o.out_bx = (longint'(w.point_x) < centre_x_r) ? negate_sat(vx) : vx[DATA_W-1:0];
    o.out_by = vy[DATA_W-1:0];
    o.out_bz = (longint'(w.point_z) < centre_z_r) ? negate_sat(vz) : vz[DATA_W-1:0];
    o.inside_res = 1'b1;
    return o;
  endfunction

  // Random component value: mostly full range, sometimes an extreme.
  function automatic logic [DATA_W-1:0] rand_comp();
    case ($urandom_range(0, 9))
      0:       return 24'h800000;
      1:       return 24'h7FFFFF;
      default: return DATA_W'($urandom());
    endcase
  endfunction

  task automatic push_load(logic [TABLE_AW-1:0] a, logic [DATA_W-1:0] bx,
                           logic [DATA_W-1:0] by, logic [DATA_W-1:0] bz);
    in_word_t w;
    w = in_word_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
    w.op = OP_LOAD;
    w.entry_index = a;
    w.load_bx = bx;
    w.load_by = by;
    w.load_bz = bz;
    loaded[a] = 1'b1;
    words_to_send.push_back(w);
    words_queued++;
  endtask

  // Queues a query; any corner of its cell not yet loaded gets a load word first.
  task automatic push_query(longint px, longint py, longint pz);
    in_word_t w;
    int       ix, iy, iz, fx, fy, fz;
    logic [TABLE_AW-1:0] a;
    w = in_word_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
    w.op = OP_QUERY;
    w.point_x = px[DATA_W-1:0];
    w.point_y = py[DATA_W-1:0];
    w.point_z = pz[DATA_W-1:0];
    if (locate_point(w, ix, iy, iz, fx, fy, fz)) begin
      for (int k = 0; k < 8; k++) begin
        a = flat_addr(ix + k[2], iy + k[1], iz + k[0]);
        if (!loaded[a]) push_load(a, rand_comp(), rand_comp(), rand_comp());
      end
    end
    words_to_send.push_back(w);
    words_queued++;
  endtask

  // Picks a local coordinate inside an axis range; folded axes need it non-negative.
  function automatic bit pick_local(longint low, int count, bit fold, output longint l);
    l = 0;
    for (int t = 0; t < 30; t++) begin
      l = low + longint'($urandom_range(0, count - 2)) * step_r
          + longint'($urandom_range(0, int'(step_r) - 1));
      if (!fold || l >= 0) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Turns a local coordinate back into a global one, on either side for folded axes.
  function automatic bit to_global(longint c, longint l, bit fold, output longint g);
    g = (fold && $urandom_range(0, 1) == 1) ? c - l : c + l;
    return g >= -8388608 && g <= 8388607;
  endfunction

  // Boundary variant of one axis: low edge, just below it, last inside value, first above.
  function automatic longint edge_local(longint low, int count);
    longint hi;
    hi = low + longint'(count - 1) * step_r;
    case ($urandom_range(0, 3))
      0:       return low;
      1:       return low - 1;
      2:       return hi - 1;
      default: return hi;
    endcase
  endfunction

  // Queues about n_words words, the loads that queries pull in included.
  task automatic push_random(int n_words);
    longint lx, ly, lz, gx, gy, gz;
    bit     ok;
    int     r;
    int     first_word;
    first_word = words_queued;
    while (words_queued - first_word < n_words) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        push_load(TABLE_AW'($urandom()), rand_comp(), rand_comp(), rand_comp());
      end else if (r < 30) begin
        push_query(longint'(signed'(24'($urandom()))), longint'(signed'(24'($urandom()))),
                   longint'(signed'(24'($urandom()))));
      end else begin
        ok = pick_local(x_low_r, GRID_X, 1'b1, lx);
        ok = pick_local(y_low_r, GRID_Y, 1'b0, ly) && ok;
        ok = pick_local(z_low_r, GRID_Z, 1'b1, lz) && ok;
        if (r < 42) begin
          case ($urandom_range(0, 2))
            0:       lx = edge_local(x_low_r, GRID_X);
            1:       ly = edge_local(y_low_r, GRID_Y);
            default: lz = edge_local(z_low_r, GRID_Z);
          endcase
          if (lx < 0) lx = -lx;
          if (lz < 0) lz = -lz;
        end
        ok = to_global(centre_x_r, lx, 1'b1, gx) && ok;
        ok = to_global(centre_y_r, ly, 1'b0, gy) && ok;
        ok = to_global(centre_z_r, lz, 1'b1, gz) && ok;
        if (ok) push_query(gx, gy, gz);
        else push_query(longint'(signed'(24'($urandom()))), centre_y_r,
                        longint'(signed'(24'($urandom()))));
      end
    end
  endtask

  // Register writes happen only with the block idle; the shadow copy follows at once.
  task automatic write_reg(logic [2:0] idx, longint v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v[23:0];
    case (idx)
      CFG_CENTRE_X: centre_x_r = longint'(signed'(v[23:0]));
      CFG_CENTRE_Y: centre_y_r = longint'(signed'(v[23:0]));
      CFG_CENTRE_Z: centre_z_r = longint'(signed'(v[23:0]));
      CFG_X_LOW:    x_low_r    = longint'(signed'(v[23:0]));
      CFG_Y_LOW:    y_low_r    = longint'(signed'(v[23:0]));
      CFG_Z_LOW:    z_low_r    = longint'(signed'(v[23:0]));
      CFG_STEP:     step_r     = longint'(v[15:0]);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(longint cx, longint cy, longint cz, longint xl, longint yl,
                            longint zl, longint st);
    write_reg(CFG_CENTRE_X, cx);
    write_reg(CFG_CENTRE_Y, cy);
    write_reg(CFG_CENTRE_Z, cz);
    write_reg(CFG_X_LOW, xl);
    write_reg(CFG_Y_LOW, yl);
    write_reg(CFG_Z_LOW, zl);
    write_reg(CFG_STEP, st);
  endtask

  // Waits until every queued word is taken and every result is back, then keeps waiting
  // so that nothing is still in flight.
  task automatic drain();
    while (words_to_send.size() != 0 || in_ch.valid || field_due.size() != 0)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // Stimulus: a short directed part at reset defaults, then random phases under
  // several configurations, including a step of 1 and the largest step.
  initial begin
    centre_x_r = 0; centre_y_r = 0; centre_z_r = 0;
    x_low_r = 0; y_low_r = -25600; z_low_r = 0;
    step_r = 640;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Cell (1,1,1) holds the most negative Bx and Bz so that the mirrored side
    // has to saturate when it negates them.
    for (int k = 0; k < 8; k++)
      push_load(flat_addr(1 + k[2], 1 + k[1], 1 + k[0]), 24'h800000, 24'h7FFFFF,
                24'h800000);
    push_query(-645, -25600 + 647, -645);
    push_query(645, -25600 + 647, 645);
    push_query(0, -25600, 0);
    push_query(63 * 640 - 1, -25600 + 15 * 640 - 1, -(63 * 640 - 1));
    push_query(63 * 640, 0, 0);
    push_query(0, -25601, 0);
    push_query(0, -25600 + 15 * 640, 0);
    push_query(-8388608, -8388608, -8388608);
    push_query(8388607, 8388607, 8388607);
    push_query(-320, -25280, 320);
    push_load(16'hFFFF, 24'h7FFFFF, 24'h800000, 24'h000000);
    push_load(16'h0000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF);
    push_random(200);
    drain();

    set_config(1000, -2000, -3000, 0, -5000, 100, 1);
    push_random(200);
    drain();

    set_config(-8388608, 8388607, 8388607, -8388608, -8388608, 8388607, 65535);
    push_random(200);
    drain();

    set_config(-12345, 777, 4321, -640, -1000, -3, 333);
    push_random(250);
    drain();

    set_config(0, 0, 0, 0, -25600, 0, 640);
    push_random(200);
    drain();

    if (fail_count == 0) begin
      $display("** field_map_trilinear_lookup_core: PASSED **");
    end else begin
      $display("** field_map_trilinear_lookup_core: FAILED **");
    end
    $finish;
  end

  // Gap lengths: mostly none or short, now and then long.
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sender: offers the next queued word after its gap; a word stays up until taken.
  int  send_gap = 0;
  int  send_run = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (send_run > 0) send_run <= send_run - 1;
      else if ($urandom_range(0, 199) == 0) send_run <= $urandom_range(50, 200);
      if (send_gap > 0 && send_run == 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (words_to_send.size() != 0) begin
        in_ch.data  <= words_to_send.pop_front();
        in_ch.valid <= 1'b1;
        send_gap    <= rand_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Input side of the monitor: each accepted word updates the shadow tables or
  // queues the result it must cause.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      words_taken <= words_taken + 1;
      if (in_ch.data.op == OP_LOAD) begin
        tab_bx[in_ch.data.entry_index] = in_ch.data.load_bx;
        tab_by[in_ch.data.entry_index] = in_ch.data.load_by;
        tab_bz[in_ch.data.entry_index] = in_ch.data.load_bz;
      end else begin
        field_due.push_back(predict_field(in_ch.data));
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off while the sender keeps offering,
  // so the output register fills and the block has to stall its input.
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  take_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && words_taken > 150) begin
      hold_done <= 1'b1;
      hold_left <= 800;
      out_ch.ready <= 1'b0;
    end else if (take_gap > 0) begin
      take_gap <= take_gap - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      take_gap <= rand_gap();
    end
  end

  // Output side of the monitor: compare each accepted result with the oldest one due.
  out_word_t due;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (field_due.size() == 0) begin
        $error("result word with none expected: %h", out_ch.data);
        fail_count = fail_count + 1;
      end else begin
        due = field_due.pop_front();
        if (out_ch.data.out_bx !== due.out_bx) begin
          $error("out_bx: expected %0d, actual %0d", due.out_bx, out_ch.data.out_bx);
          fail_count = fail_count + 1;
        end
        if (out_ch.data.out_by !== due.out_by) begin
          $error("out_by: expected %0d, actual %0d", due.out_by, out_ch.data.out_by);
          fail_count = fail_count + 1;
        end
        if (out_ch.data.out_bz !== due.out_bz) begin
          $error("out_bz: expected %0d, actual %0d", due.out_bz, out_ch.data.out_bz);
          fail_count = fail_count + 1;
        end
        if (out_ch.data.inside_res !== due.inside_res) begin
          $error("inside_res: expected %0d, actual %0d", due.inside_res,
                 out_ch.data.inside_res);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  // Run limit: far above the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("** field_map_trilinear_lookup_core: FAILED **");
      $finish;
    end
  end

endmodule
